@@ src/bbal_pkg.sv @@
`timescale 1ns / 1ps
package bbal_pkg;

   localparam int MAX_LEVELS_DEFAULT = 11;
   localparam int SIZE_W = 16;
   localparam int GRANT_W = 17;
   localparam int CFG_W = 4;
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;
   localparam int LOG_W = 5;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_step;
      logic check;
      logic write_step;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_end;
      logic found;
      logic write_last;
   } status_type;

endpackage

@@ src/buddy_block_allocator.sv @@
`timescale 1ns / 1ps
// Buddy allocator over a binary tree of power-of-two blocks.
// An item is a request with an opcode (allocate or free) and a size in units.
// It is taken when start is high and busy is low; busy stays high until the
// result has been shown. Each item gives exactly one result, present for one
// cycle with rsp_valid high: success and the size rounded up to a power of two.
// The receiver cannot stall, so a result is simply taken in that cycle.
// The block keeps, for each smallest unit, a tag of the block that holds it,
// in one RAM of 2^(MAX_LEVELS-1) entries. A request scans that RAM, reading
// and then checking each entry visited, then rewrites the entries of the
// chosen block one after another. An item that is rejected at once skips the
// scan; the worst case is an allocate of the whole memory.
// After reset a clearing pass that writes every RAM entry runs with busy
// high; the size register returns to 10 at once and may be written
// through csr_we and csr_wdata whenever the block is idle.
module buddy_block_allocator #(
   parameter int MAX_LEVELS = bbal_pkg::MAX_LEVELS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic [bbal_pkg::SIZE_W-1:0]  req_request_size,
   output logic                         rsp_valid,
   output logic                         rsp_success,
   output logic [bbal_pkg::GRANT_W-1:0] rsp_granted_size,
   input  logic                         csr_we,
   input  logic [bbal_pkg::CFG_W-1:0]   csr_wdata
);

   bbal_pkg::cmd_type    cmd;
   bbal_pkg::status_type status;

   bbal_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   bbal_dpath #(
      .MAX_LEVELS(MAX_LEVELS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_opcode),
      .req_request_size(req_request_size),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_success     (rsp_success),
      .rsp_granted_size(rsp_granted_size)
   );

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item accepted without going busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result shown twice");

   a_zero_fails: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted_size == '0) |-> !rsp_success)
      else $error("zero size reported as success");

endmodule

@@ src/bbal_ram.sv @@
`timescale 1ns / 1ps
module bbal_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

@@ src/bbal_ctrl.sv @@
`timescale 1ns / 1ps
module bbal_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  bbal_pkg::status_type status,
   output bbal_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   bbal_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbal_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bbal_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = bbal_pkg::ST_IDLE;
         end
         bbal_pkg::ST_IDLE: begin
            if (start) state_in = bbal_pkg::ST_READ;
         end
         bbal_pkg::ST_READ: begin
            state_in = status.scan_end ? bbal_pkg::ST_RESP : bbal_pkg::ST_CHECK;
         end
         bbal_pkg::ST_CHECK: begin
            state_in = status.found ? bbal_pkg::ST_WRITE : bbal_pkg::ST_READ;
         end
         bbal_pkg::ST_WRITE: begin
            if (status.write_last) state_in = bbal_pkg::ST_RESP;
         end
         bbal_pkg::ST_RESP: begin
            state_in = bbal_pkg::ST_IDLE;
         end
         default: state_in = bbal_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         bbal_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         bbal_pkg::ST_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         bbal_pkg::ST_READ: busy = 1'b1;
         bbal_pkg::ST_CHECK: cmd.check = 1'b1;
         bbal_pkg::ST_WRITE: cmd.write_step = 1'b1;
         bbal_pkg::ST_RESP: rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

@@ src/bbal_dpath.sv @@
`timescale 1ns / 1ps
module bbal_dpath #(
   parameter int MAX_LEVELS = bbal_pkg::MAX_LEVELS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bbal_pkg::cmd_type              cmd,
   output bbal_pkg::status_type           status,
   input  logic                           req_opcode,
   input  logic [bbal_pkg::SIZE_W-1:0]    req_request_size,
   input  logic                           csr_we,
   input  logic [bbal_pkg::CFG_W-1:0]     csr_wdata,
   output logic                           rsp_success,
   output logic [bbal_pkg::GRANT_W-1:0]   rsp_granted_size
);

   localparam int LEAVES = 1 << (MAX_LEVELS - 1);
   localparam int LW = (MAX_LEVELS > 1) ? MAX_LEVELS - 1 : 1;
   localparam int IW = LW + 1;
   localparam int TW = $clog2(MAX_LEVELS + 1);
   localparam int DW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   logic [bbal_pkg::CFG_W-1:0]   cfg_ff;
   logic                         op_ff;
   logic                         valid_ff;
   logic [DW-1:0]                depth_ff;
   logic [bbal_pkg::GRANT_W-1:0] granted_ff;
   logic                         ok_ff;
   logic [IW-1:0]                idx_ff, idx_in;

   logic [bbal_pkg::LOG_W-1:0] msb;
   logic [bbal_pkg::LOG_W-1:0] k;
   logic [bbal_pkg::LOG_W-1:0] t;
   logic                       pow2;
   logic [TW-1:0]              dtag;
   logic [IW-1:0]              mask;
   logic [TW-1:0]              rd_tag;
   logic                       ram_we;
   logic [TW-1:0]              ram_wdata;

   always_comb begin
      msb = '0;
      for (int b = 0; b < bbal_pkg::SIZE_W; b++) begin
         if (req_request_size[b]) msb = bbal_pkg::LOG_W'(b);
      end
      pow2 = (req_request_size & (req_request_size - 1'b1)) == '0;
      k = msb + bbal_pkg::LOG_W'(!pow2);
      if (bbal_pkg::LOG_W'(cfg_ff) > bbal_pkg::LOG_W'(MAX_LEVELS - 1)) begin
         t = bbal_pkg::LOG_W'(MAX_LEVELS - 1);
      end else begin
         t = bbal_pkg::LOG_W'(cfg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= bbal_pkg::CFG_RESET;
      end else if (csr_we) begin
         cfg_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_opcode;
         valid_ff <= (req_request_size != '0) && (k <= t);
         depth_ff <= DW'(t - k);
         granted_ff <= (req_request_size == '0) ? '0
                       : bbal_pkg::GRANT_W'(1) << k;
      end
   end

   assign dtag = TW'(depth_ff) + TW'(1);
   assign mask = ~({IW{1'b1}} << (IW'(MAX_LEVELS - 1) - IW'(depth_ff)));

   always_comb begin
      status.clear_last = idx_ff == IW'(LEAVES - 1);
      status.scan_end = !valid_ff || (idx_ff >= IW'(LEAVES));
      status.write_last = (idx_ff & mask) == mask;
      if (op_ff == bbal_pkg::OP_ALLOC) begin
         status.found = (rd_tag == '0) && ((idx_ff & mask) == mask);
      end else begin
         status.found = rd_tag == dtag;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      priority if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.clear_step || cmd.write_step) begin
         idx_in = idx_ff + 1'b1;
      end else if (cmd.check) begin
         if (status.found) begin
            idx_in = idx_ff & ~mask;
         end else if (op_ff == bbal_pkg::OP_ALLOC && rd_tag != '0) begin
            idx_in = (idx_ff | mask) + 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         ok_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.load) begin
            ok_ff <= 1'b0;
         end else if (cmd.check && status.found) begin
            ok_ff <= 1'b1;
         end
      end
   end

   assign ram_we = cmd.clear_step || cmd.write_step;
   assign ram_wdata = (cmd.write_step && op_ff == bbal_pkg::OP_ALLOC) ? dtag : '0;

   bbal_ram #(
      .WIDTH(TW),
      .DEPTH(LEAVES)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (idx_ff[LW-1:0]),
      .wdata   (ram_wdata),
      .raddr   (idx_ff[LW-1:0]),
      .rdata_ff(rd_tag)
   );

   assign rsp_success = ok_ff;
   assign rsp_granted_size = granted_ff;

endmodule

@@ tb/buddy_checker.sv @@
`timescale 1ns / 1ps
module buddy_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic                         req_opcode,
   input  logic [bbal_pkg::SIZE_W-1:0]  req_request_size,
   input  logic                         rsp_valid,
   input  logic                         rsp_success,
   input  logic [bbal_pkg::GRANT_W-1:0] rsp_granted_size,
   input  logic                         csr_we,
   input  logic [bbal_pkg::CFG_W-1:0]   csr_wdata,
   output int                           fail_count,
   output int                           pending_count
);
   import bbal_pkg::*;

   localparam int LEVELS = MAX_LEVELS_DEFAULT;
   localparam int NODES = (1 << LEVELS) - 1;

   typedef struct {
      logic               success;
      logic [GRANT_W-1:0] granted;
   } grant_t;

   bit               held[NODES];
   bit               split[NODES];
   logic [CFG_W-1:0] total_log2;
   grant_t           grants_due[$];

   function automatic int span_log2();
      return (total_log2 > LEVELS - 1) ? LEVELS - 1 : int'(total_log2);
   endfunction

   function automatic bit block_free(int depth, int off);
      int idx;
      idx = (1 << depth) - 1 + off;
      if (held[idx]) return 0;
      while (idx > 0) begin
         idx = (idx - 1) >> 1;
         if (held[idx]) return 0;
      end
      for (int e = depth + 1; e < LEVELS; e++) begin
         for (int j = off << (e - depth); j < (off + 1) << (e - depth); j++) begin
            if (held[(1 << e) - 1 + j]) return 0;
         end
      end
      return 1;
   endfunction

   function automatic bit take_block(int depth);
      int idx;
      for (int off = 0; off < (1 << depth); off++) begin
         if (block_free(depth, off)) begin
            idx = (1 << depth) - 1 + off;
            held[idx] = 1;
            while (idx > 0) begin
               idx = (idx - 1) >> 1;
               split[idx] = 1;
            end
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic bit release_block(int depth);
      for (int off = 0; off < (1 << depth); off++) begin
         if (held[(1 << depth) - 1 + off]) begin
            held[(1 << depth) - 1 + off] = 0;
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic grant_t serve_request(logic op, logic [SIZE_W-1:0] size);
      grant_t g;
      int k;
      int t;
      t = span_log2();
      k = 0;
      g.success = 0;
      g.granted = '0;
      if (size != 0) begin
         while ((1 << k) < size) k++;
         g.granted = GRANT_W'(1 << k);
         if (k <= t) g.success = (op == OP_ALLOC) ? take_block(t - k) : release_block(t - k);
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_t g;
      if (reset) begin
         foreach (held[i]) begin
            held[i] = 0;
            split[i] = 0;
         end
         total_log2 = CFG_RESET;
         grants_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (grants_due.size() == 0) begin
               $display("%0t: unexpected result success=%0b granted=%0d", $time,
                        rsp_success, rsp_granted_size);
               fail_count++;
            end else begin
               g = grants_due.pop_front();
               if (rsp_success !== g.success) begin
                  $display("%0t: success expected %0b actual %0b", $time, g.success,
                           rsp_success);
                  fail_count++;
               end
               if (rsp_granted_size !== g.granted) begin
                  $display("%0t: granted_size expected %0d actual %0d", $time, g.granted,
                           rsp_granted_size);
                  fail_count++;
               end
            end
         end
         if (start && !busy) grants_due.push_back(serve_request(req_opcode, req_request_size));
         if (csr_we) total_log2 = csr_wdata;
      end
      pending_count = grants_due.size();
   end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import bbal_pkg::*;

   localparam longint CYCLE_LIMIT = 16_000_000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_opcode;
   logic [SIZE_W-1:0]  req_request_size;
   logic               rsp_valid;
   logic               rsp_success;
   logic [GRANT_W-1:0] rsp_granted_size;
   logic               csr_we;
   logic [CFG_W-1:0]   csr_wdata;
   int                 fail_count;
   int                 pending_count;
   longint             cycles;
   int                 items_sent;
   int                 settings_used;
   bit                 steady;

   buddy_block_allocator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_request_size(req_request_size),
      .rsp_valid(rsp_valid), .rsp_success(rsp_success),
      .rsp_granted_size(rsp_granted_size),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   buddy_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_request_size(req_request_size),
      .rsp_valid(rsp_valid), .rsp_success(rsp_success),
      .rsp_granted_size(rsp_granted_size),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The start line stays high after acceptance so that back-to-back items need no gap.
   task automatic send_request(logic op, logic [SIZE_W-1:0] size);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_opcode <= op;
      req_request_size <= size;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic drain();
      start <= 0;
      @(negedge clock);
      while (pending_count != 0 || busy) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_span(logic [CFG_W-1:0] value);
      drain();
      csr_we <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      settings_used++;
   endtask

   function automatic logic [SIZE_W-1:0] pick_size(int t);
      int k;
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return '0;
      if (r < 14) return SIZE_W'($urandom);
      if (r < 20) return SIZE_W'($urandom_range((1 << t) + 1, 65535));
      k = $urandom_range(0, t);
      if (k == 0 || $urandom_range(0, 1)) return SIZE_W'(1 << k);
      return SIZE_W'($urandom_range((1 << (k - 1)) + 1, 1 << k));
   endfunction

   initial begin
      logic [CFG_W-1:0] spans[9] = '{4'd10, 4'd0, 4'd3, 4'd15, 4'd5, 4'd1, 4'd12, 4'd7, 4'd10};
      int t;
      cycles = 0;
      items_sent = 0;
      settings_used = 0;
      steady = 0;
      reset <= 1;
      start <= 0;
      req_opcode <= OP_ALLOC;
      req_request_size <= '0;
      csr_we <= 0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 0;

      send_request(OP_ALLOC, 16'd0);
      send_request(OP_FREE, 16'd0);
      send_request(OP_FREE, 16'd1);
      send_request(OP_ALLOC, 16'hFFFF);
      send_request(OP_ALLOC, 16'd1025);
      send_request(OP_ALLOC, 16'd1024);
      send_request(OP_ALLOC, 16'd1);
      send_request(OP_FREE, 16'd1024);
      send_request(OP_ALLOC, 16'd1);
      send_request(OP_ALLOC, 16'd3);
      send_request(OP_ALLOC, 16'd512);
      send_request(OP_ALLOC, 16'd1024);
      send_request(OP_ALLOC, 16'd512);
      send_request(OP_ALLOC, 16'd512);
      send_request(OP_FREE, 16'd4);
      send_request(OP_FREE, 16'd4);
      send_request(OP_FREE, 16'd1);
      send_request(OP_FREE, 16'd512);
      send_request(OP_ALLOC, 16'h8001);
      send_request(OP_FREE, 16'h5555);
      send_request(OP_ALLOC, 16'h2AAA);

      foreach (spans[p]) begin
         set_span(spans[p]);
         t = (spans[p] > MAX_LEVELS_DEFAULT - 1) ? MAX_LEVELS_DEFAULT - 1 : int'(spans[p]);
         for (int i = 0; i < 170; i++) begin
            if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            send_request(($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE, pick_size(t));
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests over %0d size settings, including zero, oversize and",
               items_sent, settings_used);
      $display("full-range sizes with random gaps and back-to-back stretches.");
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
